@@ sv/vrgb_pkg.sv @@
// Shared widths, codes, segment constants and helper functions for the colormap pipeline.
// Standalone package; used by value_to_rgb_colormap.
`default_nettype none

package vrgb_pkg;

	// Field widths
	localparam int SAMPLE_BITS = 16;
	localparam int COLOR_BITS  = 8;
	localparam int FRAC_BITS   = 16;
	localparam int V_W         = FRAC_BITS + 1;

	// Stream and register port widths
	localparam int TDATA_IN_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((3 * COLOR_BITS + 7) / 8) * 8;
	localparam int ADDR_W      = 2;

	// Divider: quotient bits retired per pipeline stage
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;

	// Pipeline stage positions
	localparam int ST_IN  = 0;
	localparam int ST_DIV = 1;
	localparam int ST_V   = ST_DIV + DIV_STAGES;
	localparam int ST_SEG = ST_V + 1;
	localparam int ST_M   = ST_V + 2;
	localparam int ST_P   = ST_V + 3;
	localparam int ST_OUT = ST_V + 4;
	localparam int NSTG   = ST_OUT + 1;

	localparam int NCH  = 3;
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;

	localparam longint CMAX  = (longint'(1) << COLOR_BITS) - 1;
	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam logic [COLOR_BITS-1:0] CMAX_C = COLOR_BITS'(CMAX);
	localparam logic [V_W-1:0] ONE_V = V_W'(ONE_Q);

	// Segment arithmetic widths
	localparam int KM_W = COLOR_BITS + 10;     // CMAX * 1000
	localparam int KW   = KM_W + V_W;          // CMAX * 1000 * v
	localparam int M_W  = COLOR_BITS + 11;     // rounded numerator
	localparam int MS_W = COLOR_BITS + 13;     // signed numerator before clipping
	localparam int D_W  = 10;                  // twice the segment width, thousandths
	localparam int R_W  = M_W - 7;             // reciprocal, divisor is at least 220
	localparam int Q_W  = M_W - 7;
	localparam int P_W  = M_W + R_W;
	localparam logic [KM_W-1:0] KMUL = KM_W'(CMAX * 1000);

	typedef enum logic [ADDR_W-1:0] {
		REG_LOWER = 2'd0,
		REG_UPPER = 2'd1,
		REG_MAP   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLP_NONE,
		CLP_ZERO,
		CLP_ONE
	} clamp_t;

	typedef struct packed {
		logic [SAMPLE_BITS:0]  rem;
		logic [DIV_STEP-1:0]   bits;
	} dstep_t;

	// One color segment: either a fixed level or a line
	// numerator = cst + floor(dy * CMAX * 1000 * v / 2^16), result = numerator / dd
	typedef struct packed {
		logic                         fixed;
		logic [COLOR_BITS-1:0]        val;
		logic signed [MS_W-1:0]       cst;
		logic signed [2:0]            dy;
		logic [D_W-1:0]               dd;
		logic [R_W-1:0]               rcp;
	} seg_t;

	// Breakpoint thresholds on v: fraction < a/1000 exactly when v < TH_a
	localparam logic [V_W-1:0] TH_110 = V_W'((110 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_125 = V_W'((125 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_340 = V_W'((340 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_350 = V_W'((350 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_375 = V_W'((375 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_500 = V_W'((500 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_640 = V_W'((640 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_650 = V_W'((650 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_660 = V_W'((660 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_890 = V_W'((890 * ONE_Q + 999) / 1000);
	localparam logic [V_W-1:0] TH_910 = V_W'((910 * ONE_Q + 999) / 1000);

	// Reciprocals of twice the segment width, scaled by 2^M_W
	localparam longint RCP_110 = (longint'(1) << M_W) / (2 * 110);
	localparam longint RCP_250 = (longint'(1) << M_W) / (2 * 250);
	localparam longint RCP_270 = (longint'(1) << M_W) / (2 * 270);
	localparam longint RCP_310 = (longint'(1) << M_W) / (2 * 310);
	localparam longint RCP_500 = (longint'(1) << M_W) / (2 * 500);

	// Retire DIV_STEP quotient bits of a restoring division
	function automatic dstep_t div_steps(logic [SAMPLE_BITS:0] rem_in,
			logic [SAMPLE_BITS-1:0] den);
		dstep_t ds;
		logic [SAMPLE_BITS:0] t;
		ds.rem = rem_in;
		ds.bits = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {ds.rem[SAMPLE_BITS-1:0], 1'b0};
			if (t >= {1'b0, den}) begin
				ds.rem = t - {1'b0, den};
				ds.bits[DIV_STEP-1-i] = 1'b1;
			end else begin
				ds.rem = t;
			end
		end
		return ds;
	endfunction

	// Line from y0/2 to y1/2 starting at a/1000, width w/1000, rounded half up
	function automatic seg_t make_lin(longint a, longint w, longint y0, longint y1,
			longint rcp);
		seg_t sg;
		sg.fixed = 1'b0;
		sg.val = '0;
		sg.cst = MS_W'(CMAX * y0 * w + w - CMAX * (y1 - y0) * a);
		sg.dy = 3'(y1 - y0);
		sg.dd = D_W'(2 * w);
		sg.rcp = R_W'(rcp);
		return sg;
	endfunction

	function automatic seg_t fixed_seg(logic [COLOR_BITS-1:0] level);
		seg_t sg;
		sg = '0;
		sg.fixed = 1'b1;
		sg.val = level;
		return sg;
	endfunction

	localparam seg_t SG_JR1 = make_lin(350, 310, 0, 2, RCP_310);
	localparam seg_t SG_JR3 = make_lin(890, 110, 2, 1, RCP_110);
	localparam seg_t SG_JG1 = make_lin(125, 250, 0, 2, RCP_250);
	localparam seg_t SG_JG3 = make_lin(640, 270, 2, 0, RCP_270);
	localparam seg_t SG_JB0 = make_lin(0, 110, 1, 2, RCP_110);
	localparam seg_t SG_JB2 = make_lin(340, 310, 2, 0, RCP_310);
	localparam seg_t SG_DR  = make_lin(0, 500, 0, 2, RCP_500);
	localparam seg_t SG_DG  = make_lin(500, 500, 2, 0, RCP_500);
	localparam seg_t SG_DB  = make_lin(0, 500, 2, 0, RCP_500);

	function automatic seg_t pick_red(logic dmap, logic [V_W-1:0] v);
		seg_t sg;
		if (dmap) begin
			sg = (v >= TH_500) ? fixed_seg(CMAX_C) : SG_DR;
		end else if (v < TH_350) begin
			sg = fixed_seg('0);
		end else if (v < TH_660) begin
			sg = SG_JR1;
		end else if (v < TH_890) begin
			sg = fixed_seg(CMAX_C);
		end else begin
			sg = SG_JR3;
		end
		return sg;
	endfunction

	function automatic seg_t pick_green(logic dmap, logic [V_W-1:0] v);
		seg_t sg;
		if (dmap) begin
			sg = (v >= TH_500) ? SG_DG : SG_DR;
		end else if (v < TH_125) begin
			sg = fixed_seg('0);
		end else if (v < TH_375) begin
			sg = SG_JG1;
		end else if (v < TH_640) begin
			sg = fixed_seg(CMAX_C);
		end else if (v < TH_910) begin
			sg = SG_JG3;
		end else begin
			sg = fixed_seg('0);
		end
		return sg;
	endfunction

	function automatic seg_t pick_blue(logic dmap, logic [V_W-1:0] v);
		seg_t sg;
		if (dmap) begin
			sg = (v >= TH_500) ? fixed_seg('0) : SG_DB;
		end else if (v < TH_110) begin
			sg = SG_JB0;
		end else if (v < TH_340) begin
			sg = fixed_seg(CMAX_C);
		end else if (v < TH_650) begin
			sg = SG_JB2;
		end else begin
			sg = fixed_seg('0);
		end
		return sg;
	endfunction

endpackage

`default_nettype wire

@@ sv/value_to_rgb_colormap.sv @@
// Throughput: one sample per clock while the output is not stalled; the slowest path
// is one pipelined divider stage (four restoring steps) or one segment multiplier,
// each between registers.
// Reset (arst_n low, asynchronous): limits and map select clear to 0, pipeline empties.
// Each stage holds its item while the stage behind it is full and stalled.
// Depends on vrgb_pkg.
`default_nettype none

module value_to_rgb_colormap (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// register write port: 0 lower_limit, 1 upper_limit, 2 map_select
	input  logic                                 cfg_we,
	input  logic [vrgb_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [vrgb_pkg::SAMPLE_BITS-1:0]     cfg_wdata,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [vrgb_pkg::TDATA_IN_W-1:0]      s_tdata,   // sample
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [vrgb_pkg::TDATA_OUT_W-1:0]     m_tdata    // red, green, blue
);

	localparam int SB   = vrgb_pkg::SAMPLE_BITS;
	localparam int CB   = vrgb_pkg::COLOR_BITS;
	localparam int FB   = vrgb_pkg::FRAC_BITS;
	localparam int NDS  = vrgb_pkg::DIV_STAGES;
	localparam int DST  = vrgb_pkg::DIV_STEP;
	localparam int NSTG = vrgb_pkg::NSTG;
	localparam int NCH  = vrgb_pkg::NCH;
	localparam int QDW  = vrgb_pkg::Q_W + vrgb_pkg::D_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [SB-1:0] lower_q;
	logic signed [SB-1:0] upper_q;
	logic                 map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
			map_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				vrgb_pkg::REG_LOWER: lower_q <= cfg_wdata;
				vrgb_pkg::REG_UPPER: upper_q <= cfg_wdata;
				vrgb_pkg::REG_MAP:   map_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: a stage takes a new item when it is empty or when the
	// stage behind it moves on, so bubbles close up during a stall.
	// ------------------------------------------------------------------
	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] adv;

	always_comb begin
		adv[NSTG-1] = !vld_s[NSTG-1] || m_tready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign s_tready = adv[vrgb_pkg::ST_IN];

	// ------------------------------------------------------------------
	// Stage 1: clamp decision, offset from the lower limit, span
	// ------------------------------------------------------------------
	logic signed [SB-1:0] smp;
	logic                 lo_hit;
	logic                 hi_hit;
	logic [SB-1:0]        diff_c;
	logic [SB-1:0]        den_c;
	vrgb_pkg::clamp_t     clp_c;

	assign smp    = s_tdata[SB-1:0];
	assign lo_hit = smp <= lower_q;
	assign hi_hit = smp >= upper_q;
	// Only meaningful when unclamped; then 0 <= diff < den < 2^SB.
	assign diff_c = smp - lower_q;
	assign den_c  = upper_q - lower_q;

	// The jet map tests the lower limit first, the diverging map the upper.
	always_comb begin
		if (!map_q && lo_hit) begin
			clp_c = vrgb_pkg::CLP_ZERO;
		end else if (hi_hit) begin
			clp_c = vrgb_pkg::CLP_ONE;
		end else if (lo_hit) begin
			clp_c = vrgb_pkg::CLP_ZERO;
		end else begin
			clp_c = vrgb_pkg::CLP_NONE;
		end
	end

	logic [SB-1:0]    diff_s1;
	logic [SB-1:0]    den_s1;
	vrgb_pkg::clamp_t clp_s1;
	logic             map_s1;

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_IN]) begin
			diff_s1 <= diff_c;
			den_s1  <= den_c;
			clp_s1  <= clp_c;
			map_s1  <= map_q;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2..5: restoring division of (diff << 16) by the span,
	// DIV_STEP quotient bits per stage, MSB first.
	// ------------------------------------------------------------------
	vrgb_pkg::dstep_t dv_nx    [NDS];
	logic [SB:0]      dv_rem_s [NDS];
	logic [FB-1:0]    dv_quo_s [NDS];
	logic [SB-1:0]    dv_den_s [NDS];
	vrgb_pkg::clamp_t dv_clp_s [NDS];
	logic             dv_map_s [NDS];

	always_comb begin
		dv_nx[0] = vrgb_pkg::div_steps({1'b0, diff_s1}, den_s1);
		for (int j = 1; j < NDS; j++) begin
			dv_nx[j] = vrgb_pkg::div_steps(dv_rem_s[j-1], dv_den_s[j-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_DIV]) begin
			dv_rem_s[0] <= dv_nx[0].rem;
			dv_quo_s[0] <= FB'(dv_nx[0].bits);
			dv_den_s[0] <= den_s1;
			dv_clp_s[0] <= clp_s1;
			dv_map_s[0] <= map_s1;
		end
		for (int j = 1; j < NDS; j++) begin
			if (adv[vrgb_pkg::ST_DIV+j]) begin
				dv_rem_s[j] <= dv_nx[j].rem;
				dv_quo_s[j] <= {dv_quo_s[j-1][FB-DST-1:0], dv_nx[j].bits};
				dv_den_s[j] <= dv_den_s[j-1];
				dv_clp_s[j] <= dv_clp_s[j-1];
				dv_map_s[j] <= dv_map_s[j-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: Q1.16 fraction v, with clamped samples forced to 0 or 1.0
	// ------------------------------------------------------------------
	logic [vrgb_pkg::V_W-1:0] v_s6;
	logic                     map_s6;

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_V]) begin
			case (dv_clp_s[NDS-1])
				vrgb_pkg::CLP_ZERO: v_s6 <= '0;
				vrgb_pkg::CLP_ONE:  v_s6 <= vrgb_pkg::ONE_V;
				default:            v_s6 <= {1'b0, dv_quo_s[NDS-1]};
			endcase
			map_s6 <= dv_map_s[NDS-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: pick the segment of each channel, scale v by CMAX * 1000
	// ------------------------------------------------------------------
	logic [vrgb_pkg::KW-1:0] kprod;
	logic [vrgb_pkg::KW-1:0] k_s7;
	vrgb_pkg::seg_t          seg_s7 [NCH];

	assign kprod = vrgb_pkg::KW'(v_s6) * vrgb_pkg::KW'(vrgb_pkg::KMUL);

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_SEG]) begin
			k_s7 <= kprod;
			seg_s7[vrgb_pkg::CH_R] <= vrgb_pkg::pick_red(map_s6, v_s6);
			seg_s7[vrgb_pkg::CH_G] <= vrgb_pkg::pick_green(map_s6, v_s6);
			seg_s7[vrgb_pkg::CH_B] <= vrgb_pkg::pick_blue(map_s6, v_s6);
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: rounded numerator per channel; the slope term is floored
	// by an arithmetic shift, the rest of the line is a segment constant.
	// ------------------------------------------------------------------
	logic signed [vrgb_pkg::KW+2:0]   dk [NCH];
	logic signed [vrgb_pkg::MS_W-1:0] ms [NCH];
	logic [vrgb_pkg::M_W-1:0]         m_s8   [NCH];
	vrgb_pkg::seg_t                   seg_s8 [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			dk[c] = $signed({1'b0, k_s7}) * seg_s7[c].dy;
			ms[c] = vrgb_pkg::MS_W'(dk[c] >>> FB) + seg_s7[c].cst;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_M]) begin
			for (int c = 0; c < NCH; c++) begin
				m_s8[c]   <= ms[c][vrgb_pkg::M_W-1:0];
				seg_s8[c] <= seg_s7[c];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: multiply by the reciprocal of the divisor
	// ------------------------------------------------------------------
	logic [vrgb_pkg::P_W-1:0] pp     [NCH];
	logic [vrgb_pkg::P_W-1:0] p_s9   [NCH];
	logic [vrgb_pkg::M_W-1:0] m_s9   [NCH];
	vrgb_pkg::seg_t           seg_s9 [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			pp[c] = vrgb_pkg::P_W'(m_s8[c]) * vrgb_pkg::P_W'(seg_s8[c].rcp);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_P]) begin
			for (int c = 0; c < NCH; c++) begin
				p_s9[c]   <= pp[c];
				m_s9[c]   <= m_s8[c];
				seg_s9[c] <= seg_s8[c];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: the estimate is the quotient or one short; fix it with one
	// compare, saturate, and hold the color in the output register.
	// ------------------------------------------------------------------
	logic [vrgb_pkg::Q_W-1:0] q0  [NCH];
	logic [QDW-1:0]           rm  [NCH];
	logic [vrgb_pkg::Q_W-1:0] qv  [NCH];
	logic [CB-1:0]            col [NCH];
	logic [CB-1:0]            rgb_s10 [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			q0[c] = p_s9[c][vrgb_pkg::P_W-1:vrgb_pkg::M_W];
			rm[c] = QDW'(m_s9[c]) - QDW'(q0[c]) * QDW'(seg_s9[c].dd);
			qv[c] = q0[c] + vrgb_pkg::Q_W'(rm[c] >= QDW'(seg_s9[c].dd));
			if (seg_s9[c].fixed) begin
				col[c] = seg_s9[c].val;
			end else if (qv[c] > vrgb_pkg::Q_W'(vrgb_pkg::CMAX)) begin
				col[c] = vrgb_pkg::CMAX_C;
			end else begin
				col[c] = qv[c][CB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[vrgb_pkg::ST_OUT]) begin
			for (int c = 0; c < NCH; c++) begin
				rgb_s10[c] <= col[c];
			end
		end
	end

	assign m_tvalid = vld_s[NSTG-1];
	assign m_tdata  = vrgb_pkg::TDATA_OUT_W'({rgb_s10[vrgb_pkg::CH_B],
		rgb_s10[vrgb_pkg::CH_G], rgb_s10[vrgb_pkg::CH_R]});

endmodule

`default_nettype wire
